// ----- rtl/core/twcr_pkg.sv -----
// shared types and constants for the textured wall column renderer
package twcr_pkg;

	localparam int SCREEN_ROWS_DEF = 480;
	localparam int TEX_SIZE_DEF    = 64;
	localparam int TEX_COUNT       = 4;
	localparam int MEM_DEPTH       = 16384;
	localparam int MEM_AW          = 14;
	localparam int DIV_DW          = 32;
	localparam int DIV_VW          = 24;
	localparam logic [23:0] SHADE_MASK = 24'd8355711;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic RES_HEADER = 1'b0;
	localparam logic RES_PIXEL  = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LH,
		S_SETUP,
		S_STEP,
		S_POS,
		S_HDR,
		S_PIX
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/twcr_if.sv -----
// request and result channel interfaces
interface twcr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [13:0] texel_index;
	logic [23:0] texel_color;
	logic [9:0]  column;
	logic [23:0] wall_distance;
	logic signed [17:0] dir_x;
	logic signed [17:0] dir_y;
	logic [23:0] pos_x;
	logic [23:0] pos_y;
	logic        hit_side;

	modport source (output valid, req_type, texel_index, texel_color, column, wall_distance,
		dir_x, dir_y, pos_x, pos_y, hit_side, input ready);
	modport sink (input valid, req_type, texel_index, texel_color, column, wall_distance,
		dir_x, dir_y, pos_x, pos_y, hit_side, output ready);
endinterface

interface twcr_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [9:0]  out_column;
	logic [11:0] out_row;
	logic [11:0] row_count;
	logic [23:0] out_color;
	logic        last_row;

	modport source (output valid, result_kind, out_column, out_row, row_count, out_color,
		last_row, input ready);
	modport sink (input valid, result_kind, out_column, out_row, row_count, out_color,
		last_row, output ready);
endinterface

// ----- rtl/core/twcr_ram.sv -----
// generic single write port ram with registered read
module twcr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/core/twcr_div.sv -----
// restoring divider, one quotient bit per cycle
module twcr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [twcr_pkg::DIV_DW-1:0]   dividend,
	input  logic [twcr_pkg::DIV_VW-1:0]   divisor,
	output twcr_pkg::div_stat_t           stat,
	output logic [twcr_pkg::DIV_DW-1:0]   quotient
);
	import twcr_pkg::*;

	localparam int CW = $clog2(DIV_DW + 1);

	logic [DIV_VW-1:0] rem_q;
	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   sh;
	logic [DIV_VW+1:0] diff;
	logic              ge;

	// trial subtract
	assign sh   = {rem_q, quo_q[DIV_DW-1]};
	assign diff = {1'b0, sh} - {2'b00, dvs_q};
	assign ge   = !diff[DIV_VW+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_VW-1:0] : sh[DIV_VW-1:0];
			quo_q <= {quo_q[DIV_DW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("divider done without run");
	a_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0 || $past(start) == 1'b0)
		else $error("divider count left over");
`endif
endmodule

// ----- rtl/core/textured_wall_column_renderer.sv -----
// textured wall column renderer top level
// start: header after S_LH divide, S_SETUP, S_STEP divide (skipped at zero height), S_POS, S_HDR
// tick: pixel registered in S_PIX from the texture ram registered read; none once the column is done
// load: written on accept; start and tick hold ready low until their result is registered
// a stalled result holds the sequencer until it is taken
// arst_n clears the sequencer and column state; texture ram is not cleared
module textured_wall_column_renderer #(
	parameter int SCREEN_ROWS = twcr_pkg::SCREEN_ROWS_DEF,
	parameter int TEX_SIZE    = twcr_pkg::TEX_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	twcr_req_if.sink   req,
	twcr_rsp_if.source rsp
);
	import twcr_pkg::*;

	localparam int HALF = SCREEN_ROWS / 2;
	localparam int TL   = $clog2(TEX_SIZE);

	state_t state_q, state_d;
	div_stat_t div_stat;
	logic [DIV_DW-1:0] quot;
	logic [DIV_DW-1:0] div_dividend;
	logic [DIV_VW-1:0] div_divisor;
	logic div_start;
	logic acc, ram_re, slot_free;

	logic [9:0]  col_q, cur_column_q;
	logic [23:0] dist_q, wpos_q;
	logic signed [17:0] wdir_q;
	logic        side_q, mirror_q, shade_side_q;
	logic [1:0]  sel_q, tex_select_q;
	logic [15:0] lh_q, off_q, prod_q;
	logic [11:0] start_q, end_q, cur_row_q, end_row_q;
	logic [31:0] step_q, tex_step_q, tex_position_q;
	logic [TL-1:0] tex_column_q;
	logic [23:0] rdata;

	logic [14:0] hl;
	logic [16:0] st_w, end_w;
	logic [15:0] frac;
	logic [TL-1:0] tx;
	logic [42:0] wprod;
	logic [31:0] addr_full;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !rsp.valid || rsp.ready;

	// shared divider
	assign div_dividend = (state_q == S_IDLE) ? DIV_DW'(SCREEN_ROWS) << 16
		: DIV_DW'(TEX_SIZE) << 16;
	assign div_divisor  = (state_q == S_IDLE) ? req.wall_distance : DIV_VW'(lh_q);

	twcr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (quot)
	);

	// texture memory
	assign addr_full = 32'(tex_select_q) * 32'(TEX_SIZE * TEX_SIZE)
		+ 32'(tex_position_q[16 +: TL]) * 32'(TEX_SIZE) + 32'(tex_column_q);

	twcr_ram #(.WIDTH(24), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (acc && req.req_type == REQ_LOAD),
		.waddr (req.texel_index),
		.wdata (req.texel_color),
		.re    (ram_re),
		.raddr (addr_full[MEM_AW-1:0]),
		.rdata (rdata)
	);

	// column geometry
	assign hl    = lh_q[15:1];
	assign st_w  = 17'(HALF) - {2'b00, hl};
	assign end_w = {2'b00, hl} + 17'(HALF);
	assign wprod = 43'($signed({1'b0, dist_q}) * wdir_q);
	assign frac  = wpos_q[15:0] + prod_q;
	assign tx    = TL'((32'(frac) * 32'(TEX_SIZE)) >> 16);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.req_type)
						REQ_START: begin
							div_start = 1'b1;
							state_d   = S_LH;
						end
						REQ_TICK: begin
							if (cur_row_q < end_row_q) begin
								ram_re  = 1'b1;
								state_d = S_PIX;
							end
						end
						default: ;
					endcase
				end
			end
			S_LH: if (div_stat.done) state_d = S_SETUP;
			S_SETUP: begin
				if (lh_q != '0) begin
					div_start = 1'b1;
					state_d   = S_STEP;
				end else begin
					state_d = S_POS;
				end
			end
			S_STEP: if (div_stat.done) state_d = S_POS;
			S_POS:  state_d = S_HDR;
			S_HDR:  if (slot_free) state_d = S_IDLE;
			S_PIX:  if (slot_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// setup working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc && req.req_type == REQ_START) begin
			col_q    <= req.column;
			dist_q   <= req.wall_distance;
			side_q   <= req.hit_side;
			wdir_q   <= req.hit_side ? req.dir_x : req.dir_y;
			wpos_q   <= req.hit_side ? req.pos_x : req.pos_y;
			sel_q    <= req.hit_side ? (req.dir_y[17] ? 2'd2 : 2'd3)
				: (req.dir_x[17] ? 2'd1 : 2'd0);
			mirror_q <= req.hit_side ? req.dir_y[17]
				: (!req.dir_x[17] && req.dir_x != '0);
		end
		if (state_q == S_LH && div_stat.done) begin
			lh_q <= (quot[DIV_DW-1:16] != '0) ? 16'hFFFF : quot[15:0];
		end
		if (state_q == S_SETUP) begin
			start_q <= st_w[16] ? 12'd0 : st_w[11:0];
			end_q   <= (end_w >= 17'(SCREEN_ROWS)) ? 12'(SCREEN_ROWS - 1) : end_w[11:0];
			off_q   <= st_w[16] ? 16'(hl) - 16'(HALF) : 16'd0;
			prod_q  <= wprod[31:16];
			step_q  <= '0;
		end
		if (state_q == S_STEP && div_stat.done) begin
			step_q <= quot;
		end
	end

	// column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_column_q   <= '0;
			cur_row_q      <= '0;
			end_row_q      <= '0;
			tex_column_q   <= '0;
			tex_select_q   <= '0;
			tex_position_q <= '0;
			tex_step_q     <= '0;
			shade_side_q   <= 1'b0;
		end else begin
			if (state_q == S_POS) begin
				cur_column_q   <= col_q;
				cur_row_q      <= start_q;
				end_row_q      <= end_q;
				tex_column_q   <= mirror_q ? TL'(TEX_SIZE - 1) - tx : tx;
				tex_select_q   <= sel_q;
				tex_position_q <= 32'(off_q) * step_q;
				tex_step_q     <= step_q;
				shade_side_q   <= side_q;
			end
			if (ram_re) begin
				tex_position_q <= tex_position_q + tex_step_q;
			end
			if (state_q == S_PIX && slot_free) begin
				cur_row_q <= cur_row_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (slot_free) begin
			rsp.valid <= (state_q == S_HDR) || (state_q == S_PIX);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && state_q == S_HDR) begin
			rsp.result_kind <= RES_HEADER;
			rsp.out_column  <= cur_column_q;
			rsp.out_row     <= cur_row_q;
			rsp.row_count   <= end_row_q - cur_row_q;
			rsp.out_color   <= '0;
			rsp.last_row    <= 1'b0;
		end else if (slot_free && state_q == S_PIX) begin
			rsp.result_kind <= RES_PIXEL;
			rsp.out_column  <= cur_column_q;
			rsp.out_row     <= cur_row_q;
			rsp.row_count   <= '0;
			rsp.out_color   <= shade_side_q ? (rdata >> 1) & SHADE_MASK : rdata;
			rsp.last_row    <= (cur_row_q + 1'b1 == end_row_q);
		end
	end

`ifndef SYNTH
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= end_row_q)
		else $error("row counter past end row");
	a_pix_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PIX |-> cur_row_q < end_row_q)
		else $error("pixel issued on finished column");
	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.last_row |-> rsp.result_kind == RES_PIXEL)
		else $error("last flag on header");
`endif
endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the textured wall column renderer
`timescale 1ns / 1ps

module testbench;
	import twcr_pkg::*;

	localparam int ROWS = SCREEN_ROWS_DEF;
	localparam int TSZ  = TEX_SIZE_DEF;
	localparam int HALF = ROWS / 2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] texel_index;
		logic [23:0] texel_color;
		logic [9:0]  column;
		logic [23:0] wall_distance;
		logic signed [17:0] dir_x;
		logic signed [17:0] dir_y;
		logic [23:0] pos_x;
		logic [23:0] pos_y;
		logic        hit_side;
	} render_req_t;

	typedef struct packed {
		logic        result_kind;
		logic [9:0]  out_column;
		logic [11:0] out_row;
		logic [11:0] row_count;
		logic [23:0] out_color;
		logic        last_row;
	} render_rsp_t;

	logic clk;
	logic arst_n;

	twcr_req_if req_ch ();
	twcr_rsp_if rsp_ch ();

	textured_wall_column_renderer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the renderer state
	logic [23:0] tex_mem [MEM_DEPTH];
	bit          tex_written [MEM_DEPTH];
	logic [9:0]  col_q;
	logic [11:0] row_q;
	logic [11:0] end_q;
	logic [5:0]  tcol_q;
	logic [1:0]  tsel_q;
	logic [31:0] tpos_q;
	logic [31:0] tstep_q;
	logic        shade_q;

	render_req_t pending_reqs[$];
	render_rsp_t expected_pixels[$];

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int n_pixels;
	int n_headers;
	int n_sent;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// column setup, mirrors the fixed point datapath
	function automatic render_rsp_t setup_column(render_req_t r);
		render_rsp_t o;
		longint unsigned q;
		longint lh, st, en, prod;
		longint unsigned up, frac, tx, pos;
		lh = 65535;
		if (r.wall_distance != 0) begin
			q = (longint'(ROWS) << 16) / longint'(r.wall_distance);
			lh = (q > 65535) ? 65535 : longint'(q);
		end
		st = HALF - lh / 2;
		if (st < 0) st = 0;
		en = lh / 2 + HALF;
		if (en >= ROWS) en = ROWS - 1;
		if (r.hit_side == 1'b0) begin
			tsel_q = (r.dir_x < 0) ? 2'd1 : 2'd0;
			prod = longint'(r.wall_distance) * longint'(r.dir_y);
			pos = r.pos_y;
		end else begin
			tsel_q = (r.dir_y < 0) ? 2'd2 : 2'd3;
			prod = longint'(r.wall_distance) * longint'(r.dir_x);
			pos = r.pos_x;
		end
		up = longint'(unsigned'(prod));
		frac = (pos + (up >> 16)) & 64'hFFFF;
		tx = (frac * TSZ) >> 16;
		if ((r.hit_side == 1'b0 && r.dir_x > 0) || (r.hit_side == 1'b1 && r.dir_y < 0))
			tx = TSZ - 1 - tx;
		tcol_q = tx[5:0];
		tstep_q = (lh == 0) ? 32'd0 : 32'((longint'(TSZ) << 16) / lh);
		tpos_q = 32'(longint'(st - HALF + lh / 2) * longint'(tstep_q));
		shade_q = r.hit_side;
		col_q = r.column;
		row_q = 12'(st);
		end_q = 12'(en);
		o = '0;
		o.result_kind = RES_HEADER;
		o.out_column = r.column;
		o.out_row = 12'(st);
		o.row_count = 12'(en - st);
		return o;
	endfunction

	function automatic logic [13:0] next_texel_addr();
		logic [5:0] ty;
		ty = tpos_q[21:16];
		return 14'(tsel_q * TSZ * TSZ + ty * TSZ + tcol_q);
	endfunction

	function automatic render_req_t random_req(logic [1:0] kind);
		render_req_t r;
		r.kind = kind;
		r.texel_index = 14'($urandom);
		r.texel_color = 24'($urandom);
		r.column = 10'($urandom);
		r.wall_distance = 24'($urandom) >> $urandom_range(0, 20);
		r.dir_x = 18'($urandom);
		r.dir_y = 18'($urandom);
		r.pos_x = 24'($urandom);
		r.pos_y = 24'($urandom);
		r.hit_side = 1'($urandom);
		return r;
	endfunction

	// queue a request and work out what it should return
	task automatic issue(render_req_t r);
		render_req_t ld;
		render_rsp_t o;
		logic [13:0] a;
		logic [23:0] c;
		case (r.kind)
			REQ_LOAD: begin
				tex_mem[r.texel_index] = r.texel_color;
				tex_written[r.texel_index] = 1'b1;
			end
			REQ_START: expected_pixels.push_back(setup_column(r));
			REQ_TICK: begin
				if (row_q < end_q) begin
					a = next_texel_addr();
					// never read a texel that was not loaded
					if (!tex_written[a]) begin
						ld = random_req(REQ_LOAD);
						ld.texel_index = a;
						pending_reqs.push_back(ld);
						tex_mem[a] = ld.texel_color;
						tex_written[a] = 1'b1;
					end
					c = tex_mem[a];
					if (shade_q) c = (c >> 1) & SHADE_MASK;
					o = '0;
					o.result_kind = RES_PIXEL;
					o.out_column = col_q;
					o.out_row = row_q;
					o.out_color = c;
					o.last_row = (row_q + 12'd1 == end_q);
					expected_pixels.push_back(o);
					tpos_q = tpos_q + tstep_q;
					row_q = row_q + 12'd1;
				end
			end
			default: ;
		endcase
		pending_reqs.push_back(r);
	endtask

	// one column: start, some ticks, with loads and noise mixed in
	task automatic random_column();
		int n;
		issue(random_req(REQ_START));
		n = end_q - row_q;
		if (n > 40) n = $urandom_range(0, 40);
		n = n + $urandom_range(0, 2);
		repeat (n) begin
			case ($urandom_range(0, 19))
				0: issue(random_req(REQ_LOAD));
				1: issue(random_req(REQ_UNUSED));
				default: issue(random_req(REQ_TICK));
			endcase
		end
	endtask

	task automatic directed_items();
		render_req_t r;
		r = random_req(REQ_LOAD);
		r.texel_index = '0; r.texel_color = '0; issue(r);
		r.texel_index = '1; r.texel_color = '1; issue(r);
		issue(random_req(REQ_TICK));
		issue(random_req(REQ_UNUSED));
		// zero distance saturates the line height
		r = random_req(REQ_START); r.wall_distance = '0; r.hit_side = 1'b0;
		r.dir_x = 18'sh1FFFF; r.dir_y = -18'sh20000; issue(r);
		repeat (3) issue(random_req(REQ_TICK));
		// far wall: line height rounds down to one, so no rows are drawn
		r = random_req(REQ_START); r.wall_distance = '1; r.hit_side = 1'b1;
		r.dir_x = -18'sh20000; r.dir_y = 18'sh1FFFF; issue(r);
		issue(random_req(REQ_TICK));
		// short column drawn out to its end, then one extra tick
		r = random_req(REQ_START); r.wall_distance = 24'h0E0000; r.hit_side = 1'b1;
		r.dir_y = -18'sd5; r.pos_x = '1; r.pos_y = '0; issue(r);
		repeat (int'(end_q - row_q) + 1) issue(random_req(REQ_TICK));
		r = random_req(REQ_START); r.wall_distance = 24'h010000; r.hit_side = 1'b0;
		r.dir_x = 18'sd0; r.dir_y = 18'sd0; r.column = '1; issue(r);
		repeat (2) issue(random_req(REQ_TICK));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		render_req_t r;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			{req_ch.req_type, req_ch.texel_index, req_ch.texel_color, req_ch.column,
				req_ch.wall_distance, req_ch.dir_x, req_ch.dir_y, req_ch.pos_x,
				req_ch.pos_y, req_ch.hit_side} <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) n_sent <= n_sent + 1;
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				r = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= r.kind;
				req_ch.texel_index <= r.texel_index;
				req_ch.texel_color <= r.texel_color;
				req_ch.column <= r.column;
				req_ch.wall_distance <= r.wall_distance;
				req_ch.dir_x <= r.dir_x;
				req_ch.dir_y <= r.dir_y;
				req_ch.pos_x <= r.pos_x;
				req_ch.pos_y <= r.pos_y;
				req_ch.hit_side <= r.hit_side;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and random stall
	always @(posedge clk or negedge arst_n) begin
		render_rsp_t got, exp_r;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.result_kind, rsp_ch.out_column, rsp_ch.out_row,
					rsp_ch.row_count, rsp_ch.out_color, rsp_ch.last_row};
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_pixels.pop_front();
					if (got.result_kind) n_pixels <= n_pixels + 1;
					else n_headers <= n_headers + 1;
					if (got !== exp_r) begin
						$display(
							"%0t: expected kind %0d col %0d row %0d cnt %0d color %h last %0d",
							$time, exp_r.result_kind, exp_r.out_column, exp_r.out_row,
							exp_r.row_count, exp_r.out_color, exp_r.last_row);
						$display(
							"%0t: actual   kind %0d col %0d row %0d cnt %0d color %h last %0d",
							$time, got.result_kind, got.out_column, got.out_row,
							got.row_count, got.out_color, got.last_row);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	// stimulus phases
	initial begin
		int phase;
		int target;
		errors = 0; n_pixels = 0; n_headers = 0; n_sent = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		col_q = '0; row_q = '0; end_q = '0; tcol_q = '0; tsel_q = '0;
		tpos_q = '0; tstep_q = '0; shade_q = 1'b0;
		@(posedge arst_n);
		directed_items();
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			target = pending_reqs.size() + 230;
			while (pending_reqs.size() < target) random_column();
			while (pending_reqs.size() > 0 || req_ch.valid || expected_pixels.size() > 0)
				@(posedge clk);
		end
		repeat (100) @(posedge clk);
		$display("requests sent %0d, headers checked %0d, pixels checked %0d",
			n_sent, n_headers, n_pixels);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
